### design/tbpp_pkg.sv
// Shared types and constants for the tuple bound permutation prune block.
// Used by tbpp_front, tbpp_queue, tbpp_back and the top level.
package tbpp_pkg;

  // Widths fixed by the port list.
  localparam int DIST_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MASK_W   = 6;
  localparam int PAIR_W   = 2;
  localparam int CODE_NUM = 3;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_02 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_02 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_12 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_12 = 3'd5;

  // Template pair codes: points {0,1}, {0,2} and {1,2}.
  localparam logic [1:0] PAIR_01 = 2'd0;
  localparam logic [1:0] PAIR_02 = 2'd1;
  localparam logic [1:0] PAIR_12 = 2'd2;

  // Template pair that each permutation maps each tuple pair onto,
  // for three-point tuples. Rows are permutations 012, 021, 102, 120,
  // 201, 210; columns are tuple pairs (0,1), (0,2), (1,2).
  localparam logic [1:0] PERM_CODE [MASK_W][CODE_NUM] = '{
    '{PAIR_01, PAIR_02, PAIR_12},
    '{PAIR_02, PAIR_01, PAIR_12},
    '{PAIR_01, PAIR_12, PAIR_02},
    '{PAIR_12, PAIR_01, PAIR_02},
    '{PAIR_02, PAIR_12, PAIR_01},
    '{PAIR_12, PAIR_02, PAIR_01}
  };

  // One classified pair, as it waits between the front and the back.
  typedef struct packed {
    logic [CODE_NUM-1:0] fit;       // interval meets the bounds, by template pair code
    logic [PAIR_W-1:0]   pair_idx;  // position of the pair within its tuple
    logic                last;      // last pair of the tuple
  } pair_entry_t;

endpackage

### design/tbpp_front.sv
// Front part: configuration registers, pair counter and bound classification.
// Depends on tbpp_pkg.
module tbpp_front #(
  parameter int TUPLE_POINTS = 3,
  parameter int DIST_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [tbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbpp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tbpp_pkg::DIST_W-1:0]     near_dist_sq,
  input  logic [tbpp_pkg::DIST_W-1:0]     far_dist_sq,
  output logic                            push_valid,
  input  logic                            push_ready,
  output tbpp_pkg::pair_entry_t           push_entry
);
  import tbpp_pkg::*;

  localparam int NUM_PAIRS = (TUPLE_POINTS == 2) ? 1 : 3;
  localparam int CMP_BITS  = (DIST_BITS < DIST_W) ? DIST_BITS : DIST_W;

  logic [CFG_W-1:0]  lower_bound [CODE_NUM];
  logic [CFG_W-1:0]  upper_bound [CODE_NUM];
  logic [PAIR_W-1:0] pair_idx;
  logic              last_pair;
  logic [CODE_NUM-1:0] fit;

  // Bound registers; write only while the block is idle, which is not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CODE_NUM; c++) begin
        lower_bound[c] <= '0;
        upper_bound[c] <= '1;
      end
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LOWER_01: lower_bound[PAIR_01] <= cfg_data;
        REG_UPPER_01: upper_bound[PAIR_01] <= cfg_data;
        REG_LOWER_02: lower_bound[PAIR_02] <= cfg_data;
        REG_UPPER_02: upper_bound[PAIR_02] <= cfg_data;
        REG_LOWER_12: lower_bound[PAIR_12] <= cfg_data;
        REG_UPPER_12: upper_bound[PAIR_12] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A pair fits a template pair unless near exceeds the upper bound or
  // far falls below the lower bound.
  always_comb begin
    for (int c = 0; c < CODE_NUM; c++) begin
      fit[c] = !((near_dist_sq[CMP_BITS-1:0] > upper_bound[c][CMP_BITS-1:0]) ||
                 (far_dist_sq[CMP_BITS-1:0] < lower_bound[c][CMP_BITS-1:0]));
    end
  end

  assign last_pair = (pair_idx == PAIR_W'(NUM_PAIRS - 1));

  // Position of the next word within its tuple.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_idx <= '0;
    end else if (in_valid && in_ready) begin
      pair_idx <= last_pair ? '0 : pair_idx + PAIR_W'(1);
    end
  end

  assign in_ready            = push_ready;
  assign push_valid          = in_valid;
  assign push_entry.fit      = fit;
  assign push_entry.pair_idx = pair_idx;
  assign push_entry.last     = last_pair;

  // The pair counter wraps back to the first pair after a tuple's last pair.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_pair) |=> (pair_idx == '0))
    else $error("pair counter did not wrap after the last pair");

endmodule

### design/tbpp_queue.sv
// Short queue of classified pairs between the front and the back.
// Depends on tbpp_pkg.
module tbpp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  tbpp_pkg::pair_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output tbpp_pkg::pair_entry_t pop_entry
);
  import tbpp_pkg::*;

  pair_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // The fill count rises by one on a push without a pop.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))
    else $error("queue count did not rise on a push");

  // The pointers are equal while the queue is empty.
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers differ while empty");

endmodule

### design/tbpp_back.sv
// Back part: permutation mask update and the registered tuple result.
// Depends on tbpp_pkg.
module tbpp_back #(
  parameter int TUPLE_POINTS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  tbpp_pkg::pair_entry_t         pop_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          tuple_viable,
  output logic [tbpp_pkg::MASK_W-1:0]   surviving_mask
);
  import tbpp_pkg::*;

  localparam int NUM_PERMS = (TUPLE_POINTS == 2) ? 2 : 6;
  localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'((1 << NUM_PERMS) - 1);

  logic [MASK_W-1:0] perm_mask;
  logic [MASK_W-1:0] clear;
  logic [MASK_W-1:0] perm_mask_next;
  logic              pop;

  // A result may only leave when the output register is free or draining.
  assign pop_ready = !pop_entry.last || !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  // Clear each permutation whose mapped template pair the interval misses.
  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      if (NUM_PERMS == 2) begin
        clear[k] = !pop_entry.fit[PAIR_01];
      end else begin
        clear[k] = !pop_entry.fit[PERM_CODE[k][pop_entry.pair_idx]];
      end
    end
    perm_mask_next = perm_mask & ~clear & FULL_MASK;
  end

  // Running mask of the tuple; a fresh tuple starts with every permutation.
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_mask <= FULL_MASK;
    end else if (pop) begin
      perm_mask <= pop_entry.last ? FULL_MASK : perm_mask_next;
    end
  end

  // Output register holding one tuple verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && pop_entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_entry.last) begin
      tuple_viable   <= (perm_mask_next != '0);
      surviving_mask <= perm_mask_next;
    end
  end

  // The verdict agrees with the mask that goes with it.
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tuple_viable == (surviving_mask != '0)))
    else $error("verdict does not match surviving mask");

  // A tuple's last word leaves a full mask for the next tuple.
  a_fresh: assert property (@(posedge clk) disable iff (rst)
    (pop && pop_entry.last) |=> (perm_mask == FULL_MASK))
    else $error("mask not refreshed after the last pair");

endmodule

### design/tuple_bound_permutation_prune_top.sv
// Top level of the tuple bound permutation prune block.
// Depends on tbpp_pkg, tbpp_front, tbpp_queue and tbpp_back.

// Each input word carries the near and far squared distance of one box pair,
// in pair order (0,1), (0,2), (1,2) for three-point tuples or (0,1) alone
// for two-point tuples. The block takes one word per cycle while the queue
// has room: the front checks the interval against all three template pairs
// in the cycle the word is accepted, a two-entry queue holds the classified
// word, and the back folds it into the permutation mask as it leaves the
// queue. The verdict of a tuple is registered in the output register as its
// last word leaves the queue and is held until taken; the back stalls only
// when a verdict is still waiting, and the queue then holds the stalled last
// word and one more word before the input stalls.
// The user writes bounds through the configuration port only while no tuple
// is in flight; the block does not enforce it. Indexes above five are ignored.
module tuple_bound_permutation_prune_top #(
  parameter int TUPLE_POINTS = 3,
  parameter int DIST_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [tbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbpp_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tbpp_pkg::DIST_W-1:0]     near_dist_sq,
  input  logic [tbpp_pkg::DIST_W-1:0]     far_dist_sq,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            tuple_viable,
  output logic [tbpp_pkg::MASK_W-1:0]     surviving_mask
);
  import tbpp_pkg::*;

  logic        push_valid;
  logic        push_ready;
  pair_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  pair_entry_t pop_entry;

  // Classification of incoming words.
  tbpp_front #(
    .TUPLE_POINTS (TUPLE_POINTS),
    .DIST_BITS    (DIST_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .near_dist_sq (near_dist_sq),
    .far_dist_sq  (far_dist_sq),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  // Decoupling queue.
  tbpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Mask update and result register.
  tbpp_back #(
    .TUPLE_POINTS (TUPLE_POINTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tuple_viable   (tuple_viable),
    .surviving_mask (surviving_mask)
  );

endmodule
